// ----- design/dbps_pkg.sv -----
// ----------------------------------------------------------------------------
// dbps_pkg: shared types and constants of the bell pulse sequencer
// Holds the phase encodings, request codes, register indexes, reset values
// and the structs that pass between the qualifier, the sequencer and the top.
// ----------------------------------------------------------------------------
package dbps_pkg;

    // Request codes carried in the input tuser field.
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_REMOTE = 2'd2
    } t_req_type;

    // Sequencer phase, as reported in ring_phase.
    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_RING  = 2'd1,
        SEQ_PAUSE = 2'd2
    } t_seq_phase;

    // Button qualifier phase, as reported in button_phase.
    typedef enum logic [1:0] {
        QUAL_IDLE      = 2'd0,
        QUAL_PRESSING  = 2'd1,
        QUAL_HELD      = 2'd2,
        QUAL_RELEASING = 2'd3
    } t_qual_phase;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_RING_MS         = 3'd0,
        CFG_PAUSE_MS        = 3'd1,
        CFG_PRESS_SAMPLES   = 3'd2,
        CFG_RELEASE_SAMPLES = 3'd3,
        CFG_BUTTON_RINGS    = 3'd4
    } t_cfg_idx;

    localparam int TIMER_W  = 16;
    localparam int SAMPLE_W = 8;
    localparam int PULSE_W  = 4;

    localparam logic [TIMER_W-1:0]  RING_MS_RST         = 16'd40;
    localparam logic [TIMER_W-1:0]  PAUSE_MS_RST        = 16'd500;
    localparam logic [SAMPLE_W-1:0] PRESS_SAMPLES_RST   = 8'd5;
    localparam logic [SAMPLE_W-1:0] RELEASE_SAMPLES_RST = 8'd5;
    localparam logic [PULSE_W-1:0]  BUTTON_RINGS_RST    = 4'd2;

    // One decoded item as it leaves the input register.
    typedef struct packed {
        logic               tick;
        logic               sample;
        logic               remote;
        logic               level;
        logic [PULSE_W-1:0] count;
    } t_item;

    // A request to start a ring sequence.
    typedef struct packed {
        logic               valid;
        logic [PULSE_W-1:0] count;
    } t_start_req;

    // Sequencer state visible in the result item.
    typedef struct packed {
        logic               drive;
        t_seq_phase         phase;
        logic [PULSE_W-1:0] pulses;
        logic               started;
    } t_seq_status;

endpackage

// ----- design/dbps_qual.sv -----
// ----------------------------------------------------------------------------
// dbps_qual: button qualifier
// Four-phase debounce of button samples; a qualified press raises a start
// request carrying the configured number of rings.
// ----------------------------------------------------------------------------
module dbps_qual
    import dbps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  t_item               i_item,
    input  logic [SAMPLE_W-1:0] i_press_samples,
    input  logic [SAMPLE_W-1:0] i_release_samples,
    input  logic [PULSE_W-1:0]  i_button_rings,
    output t_start_req          o_press_req,
    output t_qual_phase         o_phase
);

    t_qual_phase         r_phase, n_phase;
    logic [SAMPLE_W-1:0] r_count, n_count;
    logic [SAMPLE_W-1:0] need_hi, need_lo, count_inc;
    logic                fire;

    // A threshold of zero behaves as one.
    assign need_hi   = (i_press_samples == '0) ? SAMPLE_W'(1) : i_press_samples;
    assign need_lo   = (i_release_samples == '0) ? SAMPLE_W'(1) : i_release_samples;
    assign count_inc = (r_count == '1) ? r_count : r_count + SAMPLE_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        fire    = 1'b0;
        if (i_item.sample) begin
            case (r_phase)
                QUAL_IDLE: begin
                    if (i_item.level) begin
                        n_count = SAMPLE_W'(1);
                        if (need_hi == SAMPLE_W'(1)) begin
                            fire    = 1'b1;
                            n_phase = QUAL_HELD;
                        end else begin
                            n_phase = QUAL_PRESSING;
                        end
                    end
                end
                QUAL_PRESSING: begin
                    if (i_item.level) begin
                        n_count = count_inc;
                        if (count_inc >= need_hi) begin
                            fire    = 1'b1;
                            n_phase = QUAL_HELD;
                        end
                    end else begin
                        n_phase = QUAL_IDLE;
                    end
                end
                QUAL_HELD: begin
                    if (!i_item.level) begin
                        n_count = SAMPLE_W'(1);
                        n_phase = (need_lo == SAMPLE_W'(1)) ? QUAL_IDLE : QUAL_RELEASING;
                    end
                end
                QUAL_RELEASING: begin
                    if (i_item.level) begin
                        n_phase = QUAL_HELD;
                    end else begin
                        n_count = count_inc;
                        if (count_inc >= need_lo) begin
                            n_phase = QUAL_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = QUAL_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= QUAL_IDLE;
            r_count <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_press_req.valid = fire;
    assign o_press_req.count = i_button_rings;
    assign o_phase           = n_phase;

endmodule

// ----- design/dbps_seq.sv -----
// ----------------------------------------------------------------------------
// dbps_seq: bell pulse sequencer
// Rings a train of pulses on millisecond ticks; start requests are taken
// only while idle.
// ----------------------------------------------------------------------------
module dbps_seq
    import dbps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_item              i_item,
    input  t_start_req         i_press_req,
    input  logic [TIMER_W-1:0] i_ring_ms,
    input  logic [TIMER_W-1:0] i_pause_ms,
    output t_seq_status        o_status
);

    t_seq_phase         r_phase, n_phase;
    logic [PULSE_W-1:0] r_pulses, n_pulses;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_drive, n_drive;
    logic               started;
    t_start_req         req;
    logic [TIMER_W-1:0] ring_len, pause_len;

    assign ring_len  = (i_ring_ms == '0) ? TIMER_W'(1) : i_ring_ms;
    assign pause_len = (i_pause_ms == '0) ? TIMER_W'(1) : i_pause_ms;

    // Only one of the two sources can be active for a given item.
    always_comb begin
        req.valid = i_item.remote | i_press_req.valid;
        req.count = i_item.remote ? i_item.count : i_press_req.count;
    end

    always_comb begin
        n_phase  = r_phase;
        n_pulses = r_pulses;
        n_timer  = r_timer;
        n_drive  = r_drive;
        started  = 1'b0;
        if (req.valid && (r_phase == SEQ_IDLE)) begin
            started  = 1'b1;
            n_phase  = SEQ_RING;
            n_drive  = 1'b1;
            n_pulses = (req.count == '0) ? PULSE_W'(1) : req.count;
            n_timer  = ring_len;
        end else if (i_item.tick && (r_phase != SEQ_IDLE)) begin
            if (r_timer > TIMER_W'(1)) begin
                n_timer = r_timer - TIMER_W'(1);
            end else begin
                case (r_phase)
                    SEQ_RING: begin
                        n_drive = 1'b0;
                        if (r_pulses <= PULSE_W'(1)) begin
                            n_pulses = '0;
                            n_phase  = SEQ_IDLE;
                            n_timer  = '0;
                        end else begin
                            n_pulses = r_pulses - PULSE_W'(1);
                            n_phase  = SEQ_PAUSE;
                            n_timer  = pause_len;
                        end
                    end
                    SEQ_PAUSE: begin
                        n_phase = SEQ_RING;
                        n_drive = 1'b1;
                        n_timer = ring_len;
                    end
                    default: begin
                        n_phase = SEQ_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= SEQ_IDLE;
            r_pulses <= '0;
            r_timer  <= '0;
            r_drive  <= 1'b0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_pulses <= n_pulses;
            r_timer  <= n_timer;
            r_drive  <= n_drive;
        end
    end

    assign o_status.drive   = n_drive;
    assign o_status.phase   = n_phase;
    assign o_status.pulses  = n_pulses;
    assign o_status.started = started;

endmodule

// ----- design/debounced_bell_pulse_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// debounced_bell_pulse_sequencer_unit: debounced button and bell pulse train
// Qualifies button samples and rings the bell in timed pulse trains, started
// by a qualified press or by a remote request.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                    Contents
//  -------   ---------  -------------------------  -----------------------------
//  input     in         i_s_tvalid/tready/tdata    tdata: button_level, ring_count
//                       i_s_tuser                  tuser: req_type
//  result    out        o_m_tvalid/tready/tdata    tdata: bell_drive, ring_phase,
//                                                  button_phase, pulses_left,
//                                                  ring_started
//  config    in         i_cfg_we/idx/data          one register write per cycle
//
// Each item is stored in the input register and is then processed
// combinationally into the result register; one item is accepted every
// clock while results are taken. The result register is the only thing that
// can hold an item back: when it is full and not taken, processing stops and
// the input register fills, then i_s_tready drops. Reset is synchronous and
// active low; it clears all phases, counters and valid flags and loads the
// default register values.
//
module debounced_bell_pulse_sequencer_unit
    import dbps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input items.
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // [0] button_level, [4:1] ring_count
    input  logic [1:0]          i_s_tuser,   // [1:0] req_type
    // Result items.
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [15:0]         o_m_tdata,   // [0] bell_drive, [2:1] ring_phase,
                                             // [4:3] button_phase, [8:5] pulses_left,
                                             // [9] ring_started
    // Configuration writes.
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [TIMER_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [TIMER_W-1:0]  r_ring_ms;
    logic [TIMER_W-1:0]  r_pause_ms;
    logic [SAMPLE_W-1:0] r_press_samples;
    logic [SAMPLE_W-1:0] r_release_samples;
    logic [PULSE_W-1:0]  r_button_rings;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_ms         <= RING_MS_RST;
            r_pause_ms        <= PAUSE_MS_RST;
            r_press_samples   <= PRESS_SAMPLES_RST;
            r_release_samples <= RELEASE_SAMPLES_RST;
            r_button_rings    <= BUTTON_RINGS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RING_MS:         r_ring_ms         <= i_cfg_data;
                CFG_PAUSE_MS:        r_pause_ms        <= i_cfg_data;
                CFG_PRESS_SAMPLES:   r_press_samples   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_RELEASE_SAMPLES: r_release_samples <= i_cfg_data[SAMPLE_W-1:0];
                CFG_BUTTON_RINGS:    r_button_rings    <= i_cfg_data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: holds one item until the result register can take it.
    logic  r_in_valid;
    t_item r_item, n_item;
    logic  advance;

    // The item moves on when the result register is empty or being emptied.
    assign advance    = r_in_valid && (!o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_comb begin
        n_item        = '0;
        n_item.level  = i_s_tdata[0];
        n_item.count  = i_s_tdata[PULSE_W:1];
        case (t_req_type'(i_s_tuser))
            REQ_TICK:   n_item.tick   = 1'b1;
            REQ_SAMPLE: n_item.sample = 1'b1;
            REQ_REMOTE: n_item.remote = 1'b1;
            default: begin
                // The unused code reaches the result with no state change.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= n_item;
        end
    end

    // Processing: the qualifier feeds a press request into the sequencer.
    t_start_req  press_req;
    t_qual_phase qual_phase;
    t_seq_status seq_status;

    dbps_qual u_qual (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_item            (r_item),
        .i_press_samples   (r_press_samples),
        .i_release_samples (r_release_samples),
        .i_button_rings    (r_button_rings),
        .o_press_req       (press_req),
        .o_phase           (qual_phase)
    );

    dbps_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (r_item),
        .i_press_req (press_req),
        .i_ring_ms   (r_ring_ms),
        .i_pause_ms  (r_pause_ms),
        .o_status    (seq_status)
    );

    // Result register.
    logic        r_out_valid;
    logic [15:0] r_out_data, n_out_data;

    always_comb begin
        n_out_data       = '0;
        n_out_data[0]    = seq_status.drive;
        n_out_data[2:1]  = seq_status.phase;
        n_out_data[4:3]  = qual_phase;
        n_out_data[8:5]  = seq_status.pulses;
        n_out_data[9]    = seq_status.started;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
